>>> sv/keyframe_linear_interp_macros.svh
// Assertion macros shared by the keyframe interpolator RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef KEYFRAME_LINEAR_INTERP_MACROS_SVH
`define KEYFRAME_LINEAR_INTERP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KLI_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("keyframe interpolator assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define KLI_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("keyframe interpolator assertion failed");

`endif

>>> sv/kli_pkg.sv
// Shared types, sizes and codes for the keyframe interpolator.
// Depends on nothing; imported by every module of the block.
package kli_pkg;

	localparam int MAX_KEYS = 64;
	localparam int IDX_W    = $clog2(MAX_KEYS);
	localparam int CNT_W    = $clog2(MAX_KEYS + 1);
	localparam int DATA_W   = 32;

	localparam logic [1:0] CMD_CLEAR  = 2'd0;
	localparam logic [1:0] CMD_APPEND = 2'd1;
	localparam logic [1:0] CMD_SAMPLE = 2'd2;

	localparam logic [2:0] STS_CLEARED  = 3'd0;
	localparam logic [2:0] STS_APPENDED = 3'd1;
	localparam logic [2:0] STS_REFUSED  = 3'd2;
	localparam logic [2:0] STS_SAMPLED  = 3'd3;
	localparam logic [2:0] STS_EMPTY    = 3'd4;

	typedef struct packed {
		logic [1:0]               command;
		logic [DATA_W-1:0]        key_time;
		logic signed [DATA_W-1:0] key_value;
		logic [DATA_W-1:0]        sample_time;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] sampled_value;
		logic [2:0]               status;
	} rsp_t;

endpackage

>>> sv/kli_store.sv
// Keyframe table: one write port, one registered read port, times and values side by side.
// Depends on kli_pkg.
module kli_store (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [kli_pkg::IDX_W-1:0]  wr_addr,
	input  logic [kli_pkg::DATA_W-1:0] wr_time,
	input  logic [kli_pkg::DATA_W-1:0] wr_value,
	input  logic                       rd_en,
	input  logic [kli_pkg::IDX_W-1:0]  rd_addr,
	output logic [kli_pkg::DATA_W-1:0] rd_time,
	output logic [kli_pkg::DATA_W-1:0] rd_value
);
	import kli_pkg::*;

	logic [DATA_W-1:0] time_mem  [MAX_KEYS];
	logic [DATA_W-1:0] value_mem [MAX_KEYS];
	logic [DATA_W-1:0] rd_time_q;
	logic [DATA_W-1:0] rd_value_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			time_mem[wr_addr]  <= wr_time;
			value_mem[wr_addr] <= wr_value;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_time_q  <= time_mem[rd_addr];
			rd_value_q <= value_mem[rd_addr];
		end
	end

	assign rd_time  = rd_time_q;
	assign rd_value = rd_value_q;

endmodule

>>> sv/kli_div.sv
// Restoring divider, one quotient bit per cycle, 64-bit dividend by 32-bit divisor.
// The caller guarantees the quotient fits in 32 bits. Depends on kli_pkg.
module kli_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [2*kli_pkg::DATA_W-1:0] dividend,
	input  logic [kli_pkg::DATA_W-1:0]   divisor,
	output logic                         done,
	output logic [kli_pkg::DATA_W-1:0]   quotient
);
	import kli_pkg::*;

	localparam int STEP_W = $clog2(DATA_W);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] dsr_q;
	logic [DATA_W:0]   trial;
	logic [DATA_W:0]   diff;
	logic              fits;

	always_comb begin
		trial = {rem_q, quo_q[DATA_W-1]};
		diff  = trial - {1'b0, dsr_q};
		fits  = !diff[DATA_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == STEP_W'(DATA_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[2*DATA_W-1:DATA_W];
			quo_q <= dividend[DATA_W-1:0];
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
			quo_q <= {quo_q[DATA_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

>>> sv/keyframe_linear_interp.sv
// Piecewise linear keyframe curve: top level with the command sequencer.
// Depends on kli_pkg, kli_store, kli_div and keyframe_linear_interp_macros.svh.
//
// Usage: present a request (command, key_time, key_value, sample_time) and raise
// start. The transaction is accepted at the rising edge where start is high and
// busy is low. Each accepted transaction produces exactly one result, shown on
// result for a single cycle with done high; the receiver cannot hold it off.
// Clear, append, unused commands and a sample of an empty table finish at once:
// the result appears in the cycle after acceptance and busy stays low, so one
// such command per cycle. Any other sample raises busy and walks the table, one
// key per cycle through the registered read port: it issues the first read,
// compares each key as its read returns, and stops at the first key later than
// the query time or after the last key. A clamped query or one that lands on
// a key time is then finished in EVAL; an interpolation forms the
// differences in EVAL, does the 32x32 multiply in MUL, loads the divider in
// DIVGO and waits in DIVW for the bit-serial divide. The result appears in the
// cycle after the last busy cycle, when busy is already low and a new
// transaction may be accepted. Reset empties the table; the stored entries are
// not cleared.
`include "keyframe_linear_interp_macros.svh"

module keyframe_linear_interp (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  kli_pkg::req_t request,
	output logic          done,
	output kli_pkg::rsp_t result
);
	import kli_pkg::*;

	// Sequencer states.
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_EVAL  = 3'd2;
	localparam logic [2:0] ST_MUL   = 3'd3;
	localparam logic [2:0] ST_DIVGO = 3'd4;
	localparam logic [2:0] ST_DIVW  = 3'd5;

	logic [2:0]        state_q;
	logic [CNT_W-1:0]  count_q;
	logic [DATA_W-1:0] last_time_q;

	// Scan bookkeeping: the read issued last cycle is compared this cycle.
	logic [CNT_W-1:0]  rd_ptr_q;
	logic              cmp_vld_q;
	logic              have_s_q;
	logic              have_e_q;
	logic [DATA_W-1:0] t_q;
	logic [DATA_W-1:0] ts_q;
	logic [DATA_W-1:0] te_q;
	logic [DATA_W-1:0] vs_q;
	logic [DATA_W-1:0] ve_q;

	// Interpolation operands.
	logic                neg_q;
	logic [DATA_W-1:0]   mag_q;
	logic [DATA_W-1:0]   elapsed_q;
	logic [DATA_W-1:0]   span_q;
	logic [2*DATA_W-1:0] product_q;

	logic  done_q;
	rsp_t  result_q;

	logic              accept;
	logic              wr_en;
	logic              rd_en;
	logic [DATA_W-1:0] rd_time;
	logic [DATA_W-1:0] rd_value;
	logic              scan_stop;
	logic              refuse_append;
	logic              direct_hit;
	logic [DATA_W:0]   diff;
	logic              div_start;
	logic              div_done;
	logic [DATA_W-1:0] quotient;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);

	// An append is refused when the table is full or the time runs backward.
	assign refuse_append = (count_q >= CNT_W'(MAX_KEYS)) ||
		((count_q != '0) && (request.key_time < last_time_q));
	assign wr_en = accept && (request.command == CMD_APPEND) && !refuse_append;

	assign rd_en     = (state_q == ST_SCAN) && (rd_ptr_q < count_q);
	assign scan_stop = (cmp_vld_q && (rd_time > t_q)) || (!cmp_vld_q && !rd_en);

	// In EVAL the result needs no division when the query is clamped at either
	// end of the table or when both bracketing keys share one time.
	assign direct_hit = !have_s_q || !have_e_q || (te_q == ts_q);
	assign diff       = {ve_q[DATA_W-1], ve_q} - {vs_q[DATA_W-1], vs_q};
	assign div_start  = (state_q == ST_DIVGO);

	kli_store u_store (
		.clk      (clk),
		.wr_en    (wr_en),
		.wr_addr  (count_q[IDX_W-1:0]),
		.wr_time  (request.key_time),
		.wr_value (request.key_value),
		.rd_en    (rd_en),
		.rd_addr  (rd_ptr_q[IDX_W-1:0]),
		.rd_time  (rd_time),
		.rd_value (rd_value)
	);

	kli_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (product_q),
		.divisor  (span_q),
		.done     (div_done),
		.quotient (quotient)
	);

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			rd_ptr_q  <= '0;
			cmp_vld_q <= 1'b0;
			have_s_q  <= 1'b0;
			have_e_q  <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						priority if (request.command == CMD_CLEAR) begin
							count_q <= '0;
							done_q  <= 1'b1;
						end else if (request.command == CMD_APPEND) begin
							if (!refuse_append) begin
								count_q <= count_q + 1'b1;
							end
							done_q <= 1'b1;
						end else if (request.command == CMD_SAMPLE && count_q != '0) begin
							state_q   <= ST_SCAN;
							rd_ptr_q  <= '0;
							cmp_vld_q <= 1'b0;
							have_s_q  <= 1'b0;
							have_e_q  <= 1'b0;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				ST_SCAN: begin
					if (cmp_vld_q) begin
						if (rd_time <= t_q) begin
							have_s_q <= 1'b1;
						end
						if (!have_e_q && rd_time >= t_q) begin
							have_e_q <= 1'b1;
						end
					end
					if (rd_en) begin
						rd_ptr_q <= rd_ptr_q + 1'b1;
					end
					if (scan_stop) begin
						cmp_vld_q <= 1'b0;
						state_q   <= ST_EVAL;
					end else begin
						cmp_vld_q <= rd_en;
					end
				end
				ST_EVAL: begin
					if (direct_hit) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_DIVGO;
				end
				ST_DIVGO: begin
					state_q <= ST_DIVW;
				end
				ST_DIVW: begin
					if (div_done) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers; their contents matter only under the control above.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					t_q <= request.sample_time;
					result_q.sampled_value <= '0;
					priority if (request.command == CMD_CLEAR) begin
						result_q.status <= STS_CLEARED;
					end else if (request.command == CMD_APPEND) begin
						if (!refuse_append) begin
							last_time_q     <= request.key_time;
							result_q.status <= STS_APPENDED;
						end else begin
							result_q.status <= STS_REFUSED;
						end
					end else if (request.command == CMD_SAMPLE) begin
						result_q.status <= STS_EMPTY;
					end else begin
						result_q.status <= STS_REFUSED;
					end
				end
			end
			ST_SCAN: begin
				if (cmp_vld_q) begin
					if (rd_time <= t_q) begin
						ts_q <= rd_time;
						vs_q <= rd_value;
					end
					if (!have_e_q && rd_time >= t_q) begin
						te_q <= rd_time;
						ve_q <= rd_value;
					end
				end
			end
			ST_EVAL: begin
				neg_q     <= diff[DATA_W];
				mag_q     <= diff[DATA_W] ? DATA_W'(-diff) : diff[DATA_W-1:0];
				elapsed_q <= t_q - ts_q;
				span_q    <= te_q - ts_q;
				result_q.status <= STS_SAMPLED;
				// Before the first key only the end key was found: it is key zero.
				result_q.sampled_value <= have_s_q ? vs_q : ve_q;
			end
			ST_MUL: begin
				product_q <= (2*DATA_W)'(mag_q) * (2*DATA_W)'(elapsed_q);
			end
			ST_DIVGO: begin
			end
			ST_DIVW: begin
				if (div_done) begin
					result_q.sampled_value <= neg_q ? (vs_q - quotient) : (vs_q + quotient);
				end
			end
			default: begin
			end
		endcase
	end

	assign done   = done_q;
	assign result = result_q;

	`KLI_ASSERT_IMP(a_done_when_idle, clk, arst_n, done_q, state_q == ST_IDLE)
	`KLI_ASSERT_NXT(a_accept_answers, clk, arst_n, accept, done_q || busy)
	`KLI_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(MAX_KEYS))
	`KLI_ASSERT_IMP(a_scan_nonempty, clk, arst_n, state_q == ST_SCAN, count_q != '0)
	`KLI_ASSERT_IMP(a_zero_unless_sampled, clk, arst_n,
		done_q && result_q.status != STS_SAMPLED, result_q.sampled_value == '0)

endmodule

>>> tb/tb_keyframe_linear_interp.sv
// Self-checking testbench for the piecewise linear keyframe interpolator.
// Depends on kli_pkg and the keyframe_linear_interp RTL; it needs no other files.
`timescale 1ns / 1ps

module tb_keyframe_linear_interp;

	import kli_pkg::*;

	// The package names the three live commands; code 3 is refused by the block.
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;
	localparam logic [31:0] VAL_MIN  = 32'h8000_0000;
	localparam logic [31:0] VAL_MAX  = 32'h7FFF_FFFF;

	// Long enough for the slowest sample, with a full table, to finish; this covers the tail.
	localparam int DRAIN_CYCLES = 150;

	// One queued request, together with how the driver should pace it.
	typedef struct {
		req_t        req;
		bit          drain_first;   // hold off until every result is back
		int unsigned idle_pct;      // chance per cycle that the driver idles
	} pending_cmd_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	req_t request = '0;
	logic busy;
	logic done;
	rsp_t result;

	pending_cmd_t pending_cmds[$];
	rsp_t         expected_results[$];
	int           mismatch_count = 0;
	logic         handed_over = 1'b0;

	// Our own view of the keyframe table, advanced once per accepted transaction.
	logic [31:0]        key_times [MAX_KEYS];
	logic signed [31:0] key_values [MAX_KEYS];
	int                 key_count = 0;

	// Generator state: the key times the block will have accepted so far, so
	// that sample queries can be aimed at hits, gaps and the clamped ends.
	logic [31:0] gen_times[$];
	int unsigned cur_idle_pct = 24;
	bit          drain_next = 1'b0;
	int          issued_count = 0;

	keyframe_linear_interp dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.request(request),
		.done   (done),
		.result (result)
	);

	always #6 clk = ~clk;

	// Works out the result of one transaction and updates the table copy. A
	// sample finds the last key at or before the query and the first key at or
	// after it; the offset from the start value is the exact floor of
	// |dv| * elapsed / span, so it always rounds toward the start value.
	function automatic rsp_t predict_result(req_t cmd_in);
		rsp_t              r;
		int                idx, s_idx, e_idx;
		bit                have_s, have_e;
		longint            vs, ve, diff, val;
		longint unsigned   mag, elapsed, span, quot;
		r = '0;
		case (cmd_in.command)
			CMD_CLEAR: begin
				key_count = 0;
				r.status = STS_CLEARED;
			end
			CMD_APPEND: begin
				if (key_count >= MAX_KEYS ||
				    (key_count > 0 && cmd_in.key_time < key_times[key_count - 1])) begin
					r.status = STS_REFUSED;
				end else begin
					key_times[key_count] = cmd_in.key_time;
					key_values[key_count] = cmd_in.key_value;
					key_count++;
					r.status = STS_APPENDED;
				end
			end
			CMD_SAMPLE: begin
				if (key_count == 0) begin
					r.status = STS_EMPTY;
				end else begin
					have_s = 1'b0;
					have_e = 1'b0;
					s_idx = 0;
					e_idx = 0;
					for (idx = 0; idx < key_count; idx++) begin
						if (key_times[idx] <= cmd_in.sample_time) begin
							s_idx = idx;
							have_s = 1'b1;
						end
						if (!have_e && key_times[idx] >= cmd_in.sample_time) begin
							e_idx = idx;
							have_e = 1'b1;
						end
					end
					if (!have_s) begin
						val = key_values[0];
					end else if (!have_e) begin
						val = key_values[key_count - 1];
					end else begin
						vs = key_values[s_idx];
						if (key_times[e_idx] <= key_times[s_idx]) begin
							val = vs;
						end else begin
							ve = key_values[e_idx];
							span = key_times[e_idx] - key_times[s_idx];
							elapsed = cmd_in.sample_time - key_times[s_idx];
							diff = ve - vs;
							mag = (diff >= 0) ? diff : -diff;
							quot = (mag * elapsed) / span;
							val = (diff >= 0) ? vs + longint'(quot) : vs - longint'(quot);
						end
					end
					r.sampled_value = val[31:0];
					r.status = STS_SAMPLED;
				end
			end
			default: begin
				r.status = STS_REFUSED;
			end
		endcase
		return r;
	endfunction

	// Queues one request and keeps the generator's view of the table in step.
	task automatic push_cmd(logic [1:0] cmd, logic [31:0] kt, logic [31:0] kv,
	                        logic [31:0] st);
		pending_cmd_t item;
		item.req.command = cmd;
		item.req.key_time = kt;
		item.req.key_value = kv;
		item.req.sample_time = st;
		item.drain_first = drain_next;
		item.idle_pct = cur_idle_pct;
		drain_next = 1'b0;
		pending_cmds.insert(pending_cmds.size(), item);
		if (cmd == CMD_CLEAR)
			gen_times.delete();
		if (cmd == CMD_APPEND && gen_times.size() < MAX_KEYS &&
		    (gen_times.size() == 0 || kt >= gen_times[$]))
			gen_times.insert(gen_times.size(), kt);
		if (cmd != CMD_UNUSED)
			issued_count++;
	endtask

	function automatic logic [31:0] pick_key_value();
		case ($urandom_range(9))
			0: return VAL_MIN;
			1: return VAL_MAX;
			2: return 32'($urandom_range(32'h0002_0000)) - 32'h0001_0000;
			default: return $urandom();
		endcase
	endfunction

	// Query times are aimed at exact hits, the spans between keys, both clamped
	// ends and the extremes of the time range.
	function automatic logic [31:0] pick_query_time();
		int unsigned i;
		logic [31:0] lo, hi;
		if (gen_times.size() == 0)
			return $urandom();
		case ($urandom_range(7))
			0: return gen_times[$urandom_range(gen_times.size() - 1)];
			2: return (gen_times[0] == 0) ? 32'd0 : $urandom_range(gen_times[0] - 1, 0);
			3: return $urandom_range(TIME_MAX, gen_times[$]);
			4: return 32'd0;
			5: return TIME_MAX;
			6: return $urandom();
			default: begin
				if (gen_times.size() < 2)
					return gen_times[0];
				i = $urandom_range(gen_times.size() - 2);
				lo = gen_times[i];
				hi = gen_times[i + 1];
				return $urandom_range(hi, lo);
			end
		endcase
	endfunction

	// One curve: usually a clear, a run of appends in nondecreasing time order
	// with some repeated times and the odd out-of-order key, then a few samples.
	// A small share of curves fill the table and push past it.
	task automatic queue_curve();
		int unsigned n_keys, n_samples, k, pick;
		logic [31:0] t, step;
		if ($urandom_range(19) == 0)
			drain_next = 1'b1;
		if ($urandom_range(9) != 0)
			push_cmd(CMD_CLEAR, $urandom(), $urandom(), $urandom());
		if ($urandom_range(11) == 0)
			push_cmd(CMD_SAMPLE, $urandom(), $urandom(), pick_query_time());
		pick = $urandom_range(99);
		if (pick < 70)
			n_keys = $urandom_range(6, 1);
		else if (pick < 93)
			n_keys = $urandom_range(20, 7);
		else
			n_keys = MAX_KEYS + 2;
		case ($urandom_range(3))
			0: t = $urandom_range(32'h0000_FFFF);
			1: t = $urandom();
			2: t = TIME_MAX - $urandom_range(32'h000F_FFFF);
			default: t = 32'd0;
		endcase
		for (k = 0; k < n_keys; k++) begin
			case ($urandom_range(9))
				0, 1: step = 32'd0;
				2, 3, 4, 5: step = $urandom_range(32'h0004_0000, 1);
				6, 7, 8: step = $urandom_range(32'h0100_0000, 1);
				default: step = $urandom();
			endcase
			if (k > 0)
				t = (TIME_MAX - t < step) ? TIME_MAX : t + step;
			if ($urandom_range(19) == 0 && gen_times.size() != 0 && gen_times[$] != 0)
				push_cmd(CMD_APPEND, gen_times[$] - $urandom_range(gen_times[$], 1),
				         pick_key_value(), $urandom());
			push_cmd(CMD_APPEND, t, pick_key_value(), $urandom());
			if ($urandom_range(7) == 0)
				push_cmd(CMD_SAMPLE, $urandom(), $urandom(), pick_query_time());
		end
		n_samples = $urandom_range(8, 2);
		for (k = 0; k < n_samples; k++)
			push_cmd(CMD_SAMPLE, $urandom(), $urandom(), pick_query_time());
		if ($urandom_range(24) == 0)
			push_cmd(CMD_UNUSED, $urandom(), $urandom(), $urandom());
	endtask

	// Driver: works on the falling edge. A request that is presented stays
	// put until the block takes it; only then does the driver decide again
	// whether to idle or present the next one.
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || handed_over) begin
			if (pending_cmds.size() != 0 &&
			    (!pending_cmds[0].drain_first || expected_results.size() == 0) &&
			    $urandom_range(99) >= pending_cmds[0].idle_pct) begin
				start <= 1'b1;
				request <= pending_cmds[0].req;
				void'(pending_cmds.pop_front());
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: on the rising edge, checks any result against the oldest
	// expectation, then records the transaction the block takes at this edge.
	// A result never appears at the same edge as its own transaction, so
	// the order of the two steps does not matter.
	always @(posedge clk) begin
		rsp_t want;
		if (!arst_n) begin
			handed_over <= 1'b0;
		end else begin
			handed_over <= start && !busy;
			if (done) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result: status %0d sampled_value %0d",
					       result.status, result.sampled_value);
					mismatch_count++;
				end else begin
					want = expected_results.pop_front();
					if (result.sampled_value !== want.sampled_value) begin
						$error("sampled_value: expected %0d, got %0d",
						       want.sampled_value, result.sampled_value);
						mismatch_count++;
					end
					if (result.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, result.status);
						mismatch_count++;
					end
				end
			end
			if (start && !busy)
				expected_results.insert(expected_results.size(), predict_result(request));
		end
	end

	// Stimulus and the end of the run.
	initial begin
		// Directed part: empty table, extremes of time and value, repeated
		// times, out-of-order and unused commands, clamping at both ends.
		push_cmd(CMD_SAMPLE, 32'd0, 32'd0, 32'd0);
		push_cmd(CMD_UNUSED, TIME_MAX, 32'hFFFF_FFFF, TIME_MAX);
		push_cmd(CMD_CLEAR, 32'd0, 32'd0, 32'd0);
		push_cmd(CMD_SAMPLE, 32'd0, 32'd0, TIME_MAX);
		push_cmd(CMD_APPEND, 32'h0001_0000, VAL_MIN, 32'd0);
		push_cmd(CMD_SAMPLE, 32'd0, 32'd0, 32'd0);
		push_cmd(CMD_SAMPLE, 32'd0, 32'd0, 32'h0001_0000);
		push_cmd(CMD_APPEND, 32'h0001_0000, 32'd0, 32'd0);
		push_cmd(CMD_APPEND, 32'h0000_8000, VAL_MAX, 32'd0);
		push_cmd(CMD_SAMPLE, 32'd0, 32'd0, 32'h0001_0000);
		push_cmd(CMD_APPEND, TIME_MAX, VAL_MAX, 32'd0);
		push_cmd(CMD_SAMPLE, 32'd0, 32'd0, 32'h8000_0000);
		push_cmd(CMD_SAMPLE, 32'd0, 32'd0, TIME_MAX);
		push_cmd(CMD_APPEND, TIME_MAX, VAL_MIN, 32'd0);
		push_cmd(CMD_SAMPLE, 32'd0, 32'd0, TIME_MAX);
		push_cmd(CMD_SAMPLE, 32'd0, 32'd0, TIME_MAX - 1);
		push_cmd(CMD_CLEAR, TIME_MAX, 32'hFFFF_FFFF, TIME_MAX);
		push_cmd(CMD_APPEND, 32'd0, VAL_MAX, TIME_MAX);
		push_cmd(CMD_APPEND, TIME_MAX, VAL_MIN, TIME_MAX);
		push_cmd(CMD_SAMPLE, 32'd0, 32'd0, 32'h7FFF_FFFF);
		push_cmd(CMD_SAMPLE, 32'd0, 32'd0, 32'd1);
		push_cmd(CMD_UNUSED, 32'd0, 32'd0, 32'd0);
		push_cmd(CMD_SAMPLE, 32'd0, 32'd0, TIME_MAX);

		// Random part in three pacing phases: light sender idling, heavy
		// sender idling, then back to back. Each phase opens by draining.
		issued_count = 0;
		drain_next = 1'b1;
		cur_idle_pct = 24;
		while (issued_count < 400)
			queue_curve();
		drain_next = 1'b1;
		cur_idle_pct = 85;
		while (issued_count < 800)
			queue_curve();
		drain_next = 1'b1;
		cur_idle_pct = 0;
		while (issued_count < 1200)
			queue_curve();

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_cmds.size() != 0 || start || expected_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatch_count == 0 && expected_results.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// Watchdog: several times the slowest correct run.
	initial begin
		#10_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

>>> files.f
+incdir+sv
sv/kli_pkg.sv
sv/kli_store.sv
sv/kli_div.sv
sv/keyframe_linear_interp.sv
tb/tb_keyframe_linear_interp.sv
